FILE: hdl/pfm_pkg.sv
// Shared types, constants and the sine table generator for the fast match unit.
`default_nettype none

package pfm_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int COORD_FRAC_BITS_DEF = 14;

	// Cycles from an accepted request to its result strobe.
	localparam int PIPE_LATENCY = 5;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [15:0] MAX_ANGLE_ERR_RST = 16'd8192;
	localparam logic [14:0] TANGENT_PAD_RST   = 15'd410;
	localparam logic [14:0] ORTHO_PAD_RST     = 15'd2048;

	// Half a turn in 1/65536 turn units.
	localparam logic [15:0] HALF_TURN = 16'h8000;

	// pi/2 in Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// The Taylor term numerators stay below 2^34 for every table entry.
	localparam int TAYLOR_NUM_BITS = 34;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_ANGLE_ERR = 2'd0,
		REG_TANGENT_PAD   = 2'd1,
		REG_ORTHO_PAD     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] proto_x;
		logic signed [15:0] proto_y;
		logic        [14:0] proto_length;
		logic        [15:0] proto_angle;
		logic signed [15:0] feature_x;
		logic signed [15:0] feature_y;
		logic        [15:0] feature_dir;
	} req_t;

	typedef struct packed {
		logic match;
		logic angle_rejected;
	} rsp_t;

	// Per-item geometry that travels alongside the table lookup.
	typedef struct packed {
		logic        rejected;
		logic        swap;     // odd quadrant: sine and cosine entries trade places
		logic [15:0] dx_abs;
		logic [15:0] dy_abs;
		logic [16:0] l2;       // length plus twice the tangent pad
		logic [15:0] o2;       // twice the orthogonal pad
	} geom_t;

	// Truncating quotient by shift and subtract. Evaluated only at elaboration.
	function automatic longint unsigned taylor_div(longint unsigned num,
			longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 0;
		rem = 0;
		for (int i = TAYLOR_NUM_BITS - 1; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// One table entry: truncated Taylor series of sin in Q30, rounded half up
	// to Q1.frac. Evaluated only at elaboration.
	function automatic longint unsigned sine_entry(longint unsigned k, int stb, int frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned divisor;
		longint          sum;
		x    = (k * HALF_PI_Q30) >> stb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			divisor = 64'((2 * n) * (2 * n + 1));
			term = taylor_div((term * x2) >> 30, divisor);
			if ((n % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return (unsigned'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pfm_angle_stage.sv
// First pipeline stage: angle test, table addresses and coordinate deltas.
`default_nettype none

module pfm_angle_stage #(
	parameter int SINE_TABLE_BITS = pfm_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire pfm_pkg::req_t            request,
	input  wire logic [15:0]              max_angle_err,
	input  wire logic [14:0]              tangent_pad,
	input  wire logic [14:0]              ortho_pad,
	output logic                          valid_s1,
	output pfm_pkg::geom_t                geom_s1,
	output logic [SINE_TABLE_BITS:0]      addr_a_s1,
	output logic [SINE_TABLE_BITS:0]      addr_b_s1
);
	import pfm_pkg::*;

	localparam int IDX_W   = SINE_TABLE_BITS + 1;
	localparam int SHIFT   = 14 - SINE_TABLE_BITS;
	localparam int ROUND   = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
	localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(1) << SINE_TABLE_BITS;

	logic [15:0]        diff;
	logic [15:0]        diff_fold;
	logic [14:0]        within_rnd;
	logic [IDX_W-1:0]   idx;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        dx_mag;
	logic [16:0]        dy_mag;
	geom_t              geom;

	always_comb begin
		diff      = request.proto_angle - request.feature_dir;
		// Beyond half a turn the short way round is the negated difference.
		diff_fold = (diff > HALF_TURN) ? (16'd0 - diff) : diff;

		within_rnd = {1'b0, request.proto_angle[13:0]} + 15'(ROUND);
		idx        = IDX_W'(within_rnd >> SHIFT);

		dx     = 17'(request.feature_x) - 17'(request.proto_x);
		dy     = 17'(request.feature_y) - 17'(request.proto_y);
		dx_mag = dx[16] ? (17'd0 - 17'(dx)) : 17'(dx);
		dy_mag = dy[16] ? (17'd0 - 17'(dy)) : 17'(dy);

		geom.rejected = diff_fold > max_angle_err;
		geom.swap     = request.proto_angle[14];
		geom.dx_abs   = dx_mag[15:0];
		geom.dy_abs   = dy_mag[15:0];
		geom.l2       = 17'(request.proto_length) + {1'b0, tangent_pad, 1'b0};
		geom.o2       = {ortho_pad, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		geom_s1   <= geom;
		addr_a_s1 <= idx;
		addr_b_s1 <= FULL_IDX - idx;
	end

endmodule

`default_nettype wire

FILE: hdl/pfm_sine_rom.sv
// Quarter-wave sine table with two registered read ports.
`default_nettype none

module pfm_sine_rom #(
	parameter int SINE_TABLE_BITS = pfm_pkg::SINE_TABLE_BITS_DEF,
	parameter int COORD_FRAC_BITS = pfm_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic [SINE_TABLE_BITS:0]   addr_a,
	input  wire logic [SINE_TABLE_BITS:0]   addr_b,
	output logic      [COORD_FRAC_BITS:0]   data_a,
	output logic      [COORD_FRAC_BITS:0]   data_b
);
	import pfm_pkg::*;

	localparam int TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;

	typedef logic [COORD_FRAC_BITS:0] rom_arr_t [TABLE_LEN];

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int k = 0; k < TABLE_LEN; k++) begin
			r[k] = (COORD_FRAC_BITS + 1)'(sine_entry(64'(k),
				SINE_TABLE_BITS, COORD_FRAC_BITS));
		end
		return r;
	endfunction

	localparam rom_arr_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		data_a <= SINE_ROM[addr_a];
		data_b <= SINE_ROM[addr_b];
	end

endmodule

`default_nettype wire

FILE: hdl/pfm_box_test.sv
// Padded box stages: products, per-axis pad selection and the final compare.
`default_nettype none

module pfm_box_test #(
	parameter int COORD_FRAC_BITS = pfm_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_s2,
	input  wire pfm_pkg::geom_t             geom_s2,
	input  wire logic [COORD_FRAC_BITS:0]   rom_a_s2,
	input  wire logic [COORD_FRAC_BITS:0]   rom_b_s2,
	output logic                            done,
	output pfm_pkg::rsp_t                   result
);
	import pfm_pkg::*;

	// Pads live at scale 2^(F+1); a trig value times l2 needs F+18 bits.
	localparam int PROD_W = COORD_FRAC_BITS + 18;

	logic [COORD_FRAC_BITS:0] abs_sin;
	logic [COORD_FRAC_BITS:0] abs_cos;

	logic              valid_s3;
	logic              rej_s3;
	logic [PROD_W-1:0] cos_l_s3;
	logic [PROD_W-1:0] sin_o_s3;
	logic [PROD_W-1:0] sin_l_s3;
	logic [PROD_W-1:0] cos_o_s3;
	logic [PROD_W-1:0] dx_s3;
	logic [PROD_W-1:0] dy_s3;

	logic              valid_s4;
	logic              rej_s4;
	logic [PROD_W-1:0] padx_s4;
	logic [PROD_W-1:0] pady_s4;
	logic [PROD_W-1:0] dx_s4;
	logic [PROD_W-1:0] dy_s4;

	assign abs_sin = geom_s2.swap ? rom_b_s2 : rom_a_s2;
	assign abs_cos = geom_s2.swap ? rom_a_s2 : rom_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done     <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		rej_s3   <= geom_s2.rejected;
		cos_l_s3 <= PROD_W'(abs_cos) * PROD_W'(geom_s2.l2);
		sin_o_s3 <= PROD_W'(abs_sin) * PROD_W'(geom_s2.o2);
		sin_l_s3 <= PROD_W'(abs_sin) * PROD_W'(geom_s2.l2);
		cos_o_s3 <= PROD_W'(abs_cos) * PROD_W'(geom_s2.o2);
		dx_s3    <= PROD_W'(geom_s2.dx_abs) << (COORD_FRAC_BITS + 1);
		dy_s3    <= PROD_W'(geom_s2.dy_abs) << (COORD_FRAC_BITS + 1);

		rej_s4  <= rej_s3;
		padx_s4 <= (cos_l_s3 > sin_o_s3) ? cos_l_s3 : sin_o_s3;
		pady_s4 <= (sin_l_s3 > cos_o_s3) ? sin_l_s3 : cos_o_s3;
		dx_s4   <= dx_s3;
		dy_s4   <= dy_s3;

		// A rejected request never reports a match; box edges count as inside.
		result.match          <= !rej_s4 && (dx_s4 <= padx_s4) && (dy_s4 <= pady_s4);
		result.angle_rejected <= rej_s4;
	end

endmodule

`default_nettype wire

FILE: hdl/pico_feature_fast_match_unit.sv
// Top level of the pico-feature fast match unit.
// Takes one request per clock whenever start is high (busy never rises) and
// answers each in order with a one-cycle done strobe; the result must be taken
// in that cycle. The five stages are: angle test and table addressing, the
// registered sine table read (two ports, one for |sin| and one for |cos|),
// four products, pad selection, and the box compare. The table has
// 2^SINE_TABLE_BITS + 1 entries and needs no fill after reset.
// Configuration writes take effect at once and must be made while no
// request is in flight.
`default_nettype none

module pico_feature_fast_match_unit #(
	parameter int SINE_TABLE_BITS = pfm_pkg::SINE_TABLE_BITS_DEF,
	parameter int COORD_FRAC_BITS = pfm_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire pfm_pkg::req_t                      request,
	output logic                                    done,
	output pfm_pkg::rsp_t                           result,
	input  wire logic                               cfg_we,
	input  wire logic [pfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [pfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pfm_pkg::*;

	logic [15:0] max_angle_err_q;
	logic [14:0] tangent_pad_q;
	logic [14:0] ortho_pad_q;

	logic                     valid_s1;
	geom_t                    geom_s1;
	logic [SINE_TABLE_BITS:0] addr_a_s1;
	logic [SINE_TABLE_BITS:0] addr_b_s1;

	logic                     valid_s2;
	geom_t                    geom_s2;
	logic [COORD_FRAC_BITS:0] rom_a_s2;
	logic [COORD_FRAC_BITS:0] rom_b_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_angle_err_q <= MAX_ANGLE_ERR_RST;
			tangent_pad_q   <= TANGENT_PAD_RST;
			ortho_pad_q     <= ORTHO_PAD_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_ANGLE_ERR: max_angle_err_q <= cfg_wdata;
				REG_TANGENT_PAD:   tangent_pad_q   <= cfg_wdata[14:0];
				REG_ORTHO_PAD:     ortho_pad_q     <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	pfm_angle_stage #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_angle (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.request      (request),
		.max_angle_err(max_angle_err_q),
		.tangent_pad  (tangent_pad_q),
		.ortho_pad    (ortho_pad_q),
		.valid_s1     (valid_s1),
		.geom_s1      (geom_s1),
		.addr_a_s1    (addr_a_s1),
		.addr_b_s1    (addr_b_s1)
	);

	pfm_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_rom (
		.clk   (clk),
		.addr_a(addr_a_s1),
		.addr_b(addr_b_s1),
		.data_a(rom_a_s2),
		.data_b(rom_b_s2)
	);

	// Geometry is registered alongside the table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		geom_s2 <= geom_s1;
	end

	pfm_box_test #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s2(valid_s2),
		.geom_s2 (geom_s2),
		.rom_a_s2(rom_a_s2),
		.rom_b_s2(rom_b_s2),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

FILE: hdl/pfm_checker.sv
// Port-level checks on request-to-result timing and result coding.
`default_nettype none

module pfm_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire pfm_pkg::rsp_t result
);
	import pfm_pkg::*;

	// Every accepted request gets its result a fixed number of cycles later.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("accepted request produced no result on time");

	// No result appears without a request accepted that many cycles before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result strobe without a matching request");

	// A rejected angle can never also be a match.
	a_reject_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.match && result.angle_rejected))
		else $error("match and angle_rejected both set");

	// The unit never holds off requests.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind pico_feature_fast_match_unit pfm_checker u_pfm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

`default_nettype wire

FILE: dv/tb_pico_feature_fast_match_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pico-feature fast match unit.
module tb_pico_feature_fast_match_unit;
	import pfm_pkg::*;

	localparam int TBL_BITS        = SINE_TABLE_BITS_DEF;
	localparam int FRAC            = COORD_FRAC_BITS_DEF;
	localparam int TBL_FULL        = 1 << TBL_BITS;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int REPORT_LIMIT    = 10;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   done;
	req_t                   request;
	rsp_t                   result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Local copy of the quarter-wave table and of the registers.
	longint unsigned sine_rom [0:TBL_FULL];
	logic [15:0]     angle_limit;
	logic [14:0]     along_pad;
	logic [14:0]     across_pad;

	rsp_t verdict_q [$];
	int   mismatches  = 0;
	int   cycle_count = 0;
	int   burst_left  = 0;

	pico_feature_fast_match_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void build_sine_rom();
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned div;
		longint unsigned rounded;
		longint          sum;
		for (longint unsigned k = 0; k <= TBL_FULL; k++) begin
			x    = (k * HALF_PI_Q30) >> TBL_BITS;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				div  = (2 * n) * (2 * n + 1);
				term = ((term * x2) >> 30) / div;
				if ((n % 2) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			rounded     = sum;
			sine_rom[k] = (rounded + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		end
	endfunction

	function automatic void trig_mag(input logic [15:0] ang, output longint s_mag,
			output longint c_mag);
		int idx;
		idx = (int'(ang[13:0]) + ((1 << (14 - TBL_BITS)) >> 1)) >> (14 - TBL_BITS);
		if (idx > TBL_FULL) begin
			idx = TBL_FULL;
		end
		// Odd quadrants swap the roles of the direct and mirrored entries.
		if (ang[14] == 1'b0) begin
			s_mag = sine_rom[idx];
			c_mag = sine_rom[TBL_FULL - idx];
		end else begin
			s_mag = sine_rom[TBL_FULL - idx];
			c_mag = sine_rom[idx];
		end
	endfunction

	// Box half extents at scale 2^(FRAC+1).
	function automatic void box_extent(input logic [15:0] ang, input logic [14:0] len,
			output longint ext_x, output longint ext_y);
		longint s_mag;
		longint c_mag;
		longint l2;
		longint o2;
		trig_mag(ang, s_mag, c_mag);
		l2    = longint'(len) + 2 * longint'(along_pad);
		o2    = 2 * longint'(across_pad);
		ext_x = (c_mag * l2 > s_mag * o2) ? c_mag * l2 : s_mag * o2;
		ext_y = (s_mag * l2 > c_mag * o2) ? s_mag * l2 : c_mag * o2;
	endfunction

	function automatic rsp_t fast_match_verdict(input req_t r);
		rsp_t        v;
		logic [15:0] gap;
		longint      ext_x;
		longint      ext_y;
		longint      dx;
		longint      dy;
		v.match          = 1'b0;
		v.angle_rejected = 1'b0;
		gap = r.proto_angle - r.feature_dir;
		if (gap > HALF_TURN) begin
			gap = 16'd0 - gap;
		end
		if (gap > angle_limit) begin
			v.angle_rejected = 1'b1;
			return v;
		end
		box_extent(r.proto_angle, r.proto_length, ext_x, ext_y);
		dx = longint'($signed(r.feature_x)) - longint'($signed(r.proto_x));
		dy = longint'($signed(r.feature_y)) - longint'($signed(r.proto_y));
		if (dx < 0) begin
			dx = -dx;
		end
		if (dy < 0) begin
			dy = -dy;
		end
		dx = dx * (longint'(1) << (FRAC + 1));
		dy = dy * (longint'(1) << (FRAC + 1));
		v.match = (dx <= ext_x) && (dy <= ext_y);
		return v;
	endfunction

	function automatic req_t build_req(input int px, input int py, input int len,
			input int ang, input int fx, input int fy, input int dir);
		req_t r;
		r.proto_x      = 16'(px);
		r.proto_y      = 16'(py);
		r.proto_length = 15'(len);
		r.proto_angle  = 16'(ang);
		r.feature_x    = 16'(fx);
		r.feature_y    = 16'(fy);
		r.feature_dir  = 16'(dir);
		return r;
	endfunction

	function automatic req_t noise_req();
		return build_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic logic signed [15:0] clamp_coord(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	// Offset that either hugs the box edge or falls anywhere from the centre to just past it.
	function automatic longint edge_offset(input longint half);
		longint off;
		if ($urandom_range(0, 1)) begin
			off = half + int'($urandom_range(0, 2)) - 1;
		end else begin
			off = $urandom_range(0, int'(half + half / 4 + 2));
		end
		if (off < 0) begin
			off = 0;
		end
		return $urandom_range(0, 1) ? off : -off;
	endfunction

	// A request whose direction sits within or near the limit and whose point sits in or near the box.
	function automatic req_t near_edge_req(input logic [15:0] ang);
		req_t   r;
		longint ext_x;
		longint ext_y;
		int     spread;
		r.proto_x      = 16'($urandom);
		r.proto_y      = 16'($urandom);
		r.proto_length = ($urandom_range(0, 3) == 0) ? 15'($urandom)
			: 15'($urandom_range(0, 4096));
		r.proto_angle  = ang;
		spread = (angle_limit > HALF_TURN) ? 32768 : int'(angle_limit);
		if ($urandom_range(0, 1)) begin
			spread = spread + int'($urandom_range(0, 4)) - 2;
		end else begin
			spread = $urandom_range(0, spread);
		end
		if (spread < 0) begin
			spread = 0;
		end
		r.feature_dir = $urandom_range(0, 1) ? ang + 16'(spread) : ang - 16'(spread);
		box_extent(ang, r.proto_length, ext_x, ext_y);
		r.feature_x = clamp_coord(longint'($signed(r.proto_x))
			+ edge_offset(ext_x >>> (FRAC + 1)));
		r.feature_y = clamp_coord(longint'($signed(r.proto_y))
			+ edge_offset(ext_y >>> (FRAC + 1)));
		return r;
	endfunction

	task automatic note_mismatch(input string what);
		if (mismatches < REPORT_LIMIT) begin
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		end
		mismatches++;
	endtask

	// Holds the request until it is taken, then records its verdict.
	task automatic send_req(input req_t r);
		request <= r;
		start   <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		verdict_q.push_back(fast_match_verdict(r));
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_ANGLE_ERR: angle_limit = val;
			REG_TANGENT_PAD:   along_pad   = val[14:0];
			REG_ORTHO_PAD:     across_pad  = val[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] lim, input logic [14:0] tp,
			input logic [14:0] op);
		wait_idle();
		write_reg(REG_MAX_ANGLE_ERR, lim);
		write_reg(REG_TANGENT_PAD, {1'b0, tp});
		write_reg(REG_ORTHO_PAD, {1'b0, op});
	endtask

	task automatic run_random_phase(input int n, input bit hold_midway);
		for (int i = 0; i < n; i++) begin
			if (hold_midway && i == n / 2) begin
				wait_idle();
			end
			if ($urandom_range(0, 3) == 0) begin
				send_req(noise_req());
			end else begin
				send_req(near_edge_req(16'($urandom)));
			end
			pace();
		end
	endtask

	task automatic test_reset_config();
		send_req(build_req(0, 0, 0, 0, 0, 0, 0));
		send_req(build_req(32767, -32768, 32767, 16'hFFFF, -32768, 32767, 16'hFFFF));
		send_req(build_req(-32768, 32767, 0, 0, 32767, -32768, 0));
		// Direction difference exactly at the limit from both sides, one past it, and a full half turn.
		send_req(build_req(0, 0, 1000, 0, 0, 0, 16'hE000));
		send_req(build_req(0, 0, 1000, 0, 0, 0, 16'hDFFF));
		send_req(build_req(0, 0, 1000, 0, 0, 0, 16'h2000));
		send_req(build_req(0, 0, 1000, 0, 0, 0, 16'h8000));
		send_req(build_req(50, 50, 1000, 16'hFFF0, 60, 40, 16'h0010));
		send_req(near_edge_req(16'h4000));
		send_req(near_edge_req(16'h8000));
		send_req(near_edge_req(16'hC000));
		send_req(near_edge_req(16'h3FFF));
		send_req(near_edge_req(16'h0008));
	endtask

	task automatic test_angle_limits();
		set_config(16'd0, TANGENT_PAD_RST, ORTHO_PAD_RST);
		send_req(build_req(0, 0, 0, 16'h1234, 0, 0, 16'h1234));
		send_req(build_req(0, 0, 0, 16'h1234, 0, 0, 16'h1235));
		// A limit of half a turn lets every direction through.
		set_config(HALF_TURN, TANGENT_PAD_RST, ORTHO_PAD_RST);
		send_req(build_req(0, 0, 0, 0, 0, 0, 16'h8000));
		send_req(build_req(0, 0, 0, 16'h4321, 0, 0, 16'hC321));
	endtask

	task automatic test_degenerate_box();
		// With no pads and no length the box is the centre point alone.
		set_config(MAX_ANGLE_ERR_RST, 15'd0, 15'd0);
		send_req(build_req(100, -200, 0, 16'h2000, 100, -200, 16'h2000));
		send_req(build_req(100, -200, 0, 16'h2000, 101, -200, 16'h2000));
		send_req(build_req(100, -200, 0, 16'h2000, 100, -201, 16'h2000));
	endtask

	task automatic test_unmapped_index();
		set_config(MAX_ANGLE_ERR_RST, TANGENT_PAD_RST, ORTHO_PAD_RST);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		send_req(near_edge_req(16'($urandom)));
		send_req(near_edge_req(16'($urandom)));
	endtask

	task automatic test_config_sweep();
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_config(MAX_ANGLE_ERR_RST, TANGENT_PAD_RST, ORTHO_PAD_RST);
				1: set_config(16'd0, 15'd0, 15'd0);
				2: set_config(HALF_TURN, 15'h7FFF, 15'h7FFF);
				4: set_config(16'd16384, 15'd1, 15'h7FFF);
				default: set_config(16'($urandom_range(0, 32768)), 15'($urandom),
					15'($urandom_range(0, 4096)));
			endcase
			run_random_phase(ITEMS_PER_PHASE, p == 3);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done !== 1'b0) begin
			if (verdict_q.size() == 0) begin
				note_mismatch($sformatf("result %b with no request pending", result));
			end else begin
				want = verdict_q.pop_front();
				if (result.match !== want.match
						|| result.angle_rejected !== want.angle_rejected) begin
					note_mismatch($sformatf(
						"match exp %b got %b, angle_rejected exp %b got %b",
						want.match, result.match, want.angle_rejected,
						result.angle_rejected));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		build_sine_rom();
		angle_limit = MAX_ANGLE_ERR_RST;
		along_pad   = TANGENT_PAD_RST;
		across_pad  = ORTHO_PAD_RST;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		request   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_angle_limits();
		test_degenerate_box();
		test_unmapped_index();
		test_config_sweep();
		wait_idle();
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
